// ----- hdl/ssm_pkg.sv -----
// Package for the substring first-match block: sizes, register indexes,
// and the packed item types used by the top level and ssm_cfg. No dependencies.
package ssm_pkg;

  // Window depth and saturating text count limit
  localparam int MAX_PATTERN = 32;
  localparam int MAX_TEXT    = 65536;

  // Pattern storage is fixed at four 64-bit registers
  localparam int PAT_BYTES = 32;
  localparam int PAT_IDX_W = 5;
  localparam int PAT_W     = PAT_BYTES * 8;
  localparam int LEN_W     = 6;
  localparam int CNT_W     = $clog2(MAX_TEXT) + 1;
  localparam int START_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW    = 3'd0,
    REG_PAT_SECOND = 3'd1,
    REG_PAT_THIRD  = 3'd2,
    REG_PAT_HIGH   = 3'd3,
    REG_PAT_LEN    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
    logic               overflow;
  } out_item_t;

  // Settings handed from the register file to the search logic
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length;
  } cfg_t;

endpackage

// ----- hdl/substring_first_match.sv -----
// Top level of the substring first-match block: window cell chain, byte
// count, match tracking and result register. Depends on ssm_pkg, ssm_cfg
// and ssm_cell.
//
// The block takes one text byte per cycle and keeps going without gaps as
// long as the result register is free or being drained. A row of window
// cells, one per pattern byte, shifts the text by one byte per counted byte
// and compares the newest pattern_length bytes with the pattern in the same
// cycle. After the byte marked last, the result (found, start of the first
// match, overflow) appears in the output register on the next cycle, and the
// next text may begin in that same cycle. Input stalls only while a result
// waits to be taken. Write configuration only while no text is in flight.
module substring_first_match
  import ssm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic [CNT_W-1:0]   bytes_seen;
  logic               match_seen;
  logic [START_W-1:0] first_match_start;
  logic               count_overflowed;

  logic [7:0]             window [MAX_PATTERN];
  logic [7:0]             cell_in [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_hit;

  logic               accept;
  logic               at_max;
  logic               step;
  logic [CNT_W-1:0]   count_inc;
  logic               new_match;
  logic [START_W-1:0] start_now;
  logic               match_any;
  logic [START_W-1:0] start_any;
  logic               ovf_any;

  assign cfg_ready = 1'b1;

  ssm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Build the cell chain; cell k is matched against pattern byte len-1-k
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [PAT_IDX_W-1:0] pat_idx;
    logic                 active;

    assign pat_idx = PAT_IDX_W'(cfg.length - LEN_W'(k + 1));
    assign active  = cfg.length > LEN_W'(k);

    if (k == 0) begin : g_head
      assign cell_in[k] = in_data.text_byte;
    end else begin : g_body
      assign cell_in[k] = window[k-1];
    end

    ssm_cell u_cell (
      .clk      (clk),
      .shift    (step),
      .byte_in  (cell_in[k]),
      .pat_byte (cfg.pattern[{pat_idx, 3'b000} +: 8]),
      .active   (active),
      .byte_out (window[k]),
      .hit      (cell_hit[k])
    );
  end

  // Accept while the result register is free or being drained
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign at_max    = bytes_seen == CNT_W'(MAX_TEXT);
  assign step      = accept && !at_max;
  assign count_inc = bytes_seen + CNT_W'(1);

  // Detect the first complete match within the counted text
  assign new_match = step && !match_seen && (cfg.length != '0)
                     && (count_inc >= CNT_W'(cfg.length)) && (&cell_hit);
  assign start_now = START_W'(count_inc - CNT_W'(cfg.length));
  assign match_any = match_seen || new_match;
  assign start_any = match_seen ? first_match_start : start_now;
  assign ovf_any   = count_overflowed || (accept && at_max);

  // Track stream state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen        <= '0;
      match_seen        <= 1'b0;
      first_match_start <= '0;
      count_overflowed  <= 1'b0;
    end else if (accept) begin
      if (in_data.last_byte) begin
        bytes_seen        <= '0;
        match_seen        <= 1'b0;
        first_match_start <= '0;
        count_overflowed  <= 1'b0;
      end else begin
        if (step) begin
          bytes_seen <= count_inc;
        end
        match_seen        <= match_any;
        first_match_start <= match_any ? start_any : '0;
        count_overflowed  <= ovf_any;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_data.found       <= match_any;
      out_data.match_start <= match_any ? start_any : '0;
      out_data.overflow    <= ovf_any;
    end
  end

  // Count never runs past its saturation limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= CNT_W'(MAX_TEXT))
    else $error("byte count exceeded its limit");

  // Overflow is only flagged once the count has saturated
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    count_overflowed |-> at_max)
    else $error("overflow flagged before count saturated");

  // Stream state is cleared and a result is posted after the last byte
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.last_byte) |=> (out_valid && bytes_seen == '0
                                       && !match_seen && !count_overflowed))
    else $error("stream state not cleared after last byte");

  // A not-found result carries a zero start index
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.match_start == '0))
    else $error("start index set on a not-found result");

  // Without a recorded match the stored start stays zero
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    !match_seen |-> (first_match_start == '0))
    else $error("start index held without a match");

endmodule

// ----- hdl/ssm_cfg.sv -----
// Configuration register file for the substring first-match block.
// Depends on ssm_pkg for register indexes and the cfg_t struct.
module ssm_cfg
  import ssm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [CFG_DATA_W-1:0] pat_low;
  logic [CFG_DATA_W-1:0] pat_second;
  logic [CFG_DATA_W-1:0] pat_third;
  logic [CFG_DATA_W-1:0] pat_high;
  logic [LEN_W-1:0]      pat_len;

  // Decode writes into the register selected by index
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low    <= '0;
      pat_second <= '0;
      pat_third  <= '0;
      pat_high   <= '0;
      pat_len    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAT_LOW:    pat_low    <= cfg_data;
        REG_PAT_SECOND: pat_second <= cfg_data;
        REG_PAT_THIRD:  pat_third  <= cfg_data;
        REG_PAT_HIGH:   pat_high   <= cfg_data;
        REG_PAT_LEN:    pat_len    <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to the window depth
  always_comb begin
    cfg.pattern = {pat_high, pat_third, pat_second, pat_low};
    if (pat_len > LEN_W'(MAX_PATTERN)) begin
      cfg.length = LEN_W'(MAX_PATTERN);
    end else begin
      cfg.length = pat_len;
    end
  end

endmodule

// ----- hdl/ssm_cell.sv -----
// One window cell: holds one text byte, passes it to the next cell on each
// shift and compares its incoming byte with its aligned pattern byte.
// Depends on ssm_pkg (no types used beyond plain vectors).
module ssm_cell
  import ssm_pkg::*;
(
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  input  logic       active,
  output logic [7:0] byte_out,
  output logic       hit
);

  logic [7:0] held;

  // Advance the window byte
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;

  // Compare the byte this cell takes on the current shift
  assign hit = !active || (byte_in == pat_byte);

endmodule
